// ===== hdl/mpc_pkg.sv =====
// Shared types, constants and the 64-bit popcount helper for the masked
// popcount contingency counter. No dependencies.
`default_nettype none

package mpc_pkg;

   localparam int unsigned NUM_REF          = 3;
   localparam int unsigned WORD_W           = 64;
   localparam int unsigned REF_ROW_W        = 2;
   localparam int unsigned WIDX_W           = 10;
   localparam int unsigned WIDX_EXT_W       = 17;
   localparam int unsigned WPR_W            = 11;
   localparam int unsigned ROWCNT_W         = 13;
   localparam int unsigned CSR_DATA_W       = 13;
   localparam int unsigned ROW_W            = 12;
   localparam int unsigned ENTRY_W          = 14;
   localparam int unsigned COUNT_W          = 17;
   localparam int unsigned PC_W             = 7;
   localparam int unsigned SEL_W            = 2;
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned QPTR_W           = 2;
   localparam int unsigned QCNT_W           = 3;
   localparam int unsigned DEF_MAX_WORDS    = 1024;
   localparam int unsigned DEF_MAX_ROWS     = 4096;

   localparam logic [SEL_W-1:0]   LAST_SEL  = SEL_W'(NUM_REF - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [0:0] {
      MODE_LOAD   = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      CSR_WORDS_PER_ROW = 1'b0,
      CSR_ROW_COUNT     = 1'b1
   } csr_index_type;

   typedef struct packed {
      mode_type               mode;
      logic [REF_ROW_W-1:0]   ref_row;
      logic [WIDX_W-1:0]      word_index;
      logic [WORD_W-1:0]      data_word;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]     entry_index;
      logic [COUNT_W-1:0]     count;
      logic                   last;
   } rsp_type;

   // One sample word after masking with the three reference words.
   typedef struct packed {
      logic                              row_end;
      logic [NUM_REF-1:0][WORD_W-1:0]    word;
   } q_entry_type;

   function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] t1;
      logic [WORD_W-1:0] t2;
      logic [WORD_W-1:0] t3;
      logic [PC_W-1:0]   acc;
      t1 = v - ((v >> 1) & {8{8'h55}});
      t2 = (t1 & {8{8'h33}}) + ((t1 >> 2) & {8{8'h33}});
      t3 = (t2 + (t2 >> 4)) & {8{8'h0F}};
      acc = '0;
      for (int b = 0; b < 8; b++) begin
         acc = acc + PC_W'(t3[b*8 +: 8]);
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/masked_popcount_contingency.sv =====
// Top level of the masked popcount contingency counter: control registers,
// front end, decoupling queue and back end. Depends on mpc_pkg, mpc_front,
// mpc_queue and mpc_back.
//
// Channels:
//   - csr_: write words_per_row (index 0) and row_count (index 1) while idle;
//     a write lands at the edge where csr_we is high.
//   - req_: mode 0 loads one reference word, mode 1 streams one sample word that
//     is ANDed with the three reference words at its index and counted into three
//     saturating counters. The word at index words_per_row - 1 closes the row.
//   - rsp_: three responses per closed row, entry sample_row*3+j, last on the third.
// Timing:
//   - One request per cycle while req_ready is high. rsp_valid rises once the closing word
//     has passed the front register, the queue and stages pa and pb; the three responses
//     leave on consecutive cycles while rsp_ready is high, which paces one-word rows.
//   - A stalled receiver holds the response register; words keep being counted up
//     to the next row end, then the four-entry queue fills and req_ready drops.
// Reset: clears counters, sample row and valids and sets both registers to 1;
//   reference memory is not cleared, so read only words that were loaded.
`default_nettype none

module masked_popcount_contingency
   import mpc_pkg::*;
#(
   parameter int unsigned MAX_WORDS = DEF_MAX_WORDS,
   parameter int unsigned MAX_ROWS  = DEF_MAX_ROWS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire req_type                req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_type                rsp_data,
   input  wire logic                   csr_we,
   input  wire csr_index_type          csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Control registers, reset to one word per row and one row per table.
   logic [WPR_W-1:0]    words_per_row_ff, words_per_row_in;
   logic [ROWCNT_W-1:0] row_count_ff, row_count_in;

   // Front end to queue, queue to back end.
   logic                f_push_valid, f_push_ready;
   q_entry_type         f_push_data;
   logic                b_pop_valid, b_pop_ready;
   q_entry_type         b_pop_data;

   always_comb begin
      words_per_row_in = words_per_row_ff;
      row_count_in     = row_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WORDS_PER_ROW: words_per_row_in = csr_wdata[WPR_W-1:0];
            CSR_ROW_COUNT:     row_count_in     = csr_wdata[ROWCNT_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_per_row_ff <= WPR_W'(1);
         row_count_ff     <= ROWCNT_W'(1);
      end else begin
         words_per_row_ff <= words_per_row_in;
         row_count_ff     <= row_count_in;
      end
   end

   // Classify, store reference words, read and mask sample words.
   mpc_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .words_per_row (words_per_row_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .push_valid    (f_push_valid),
      .push_ready    (f_push_ready),
      .push_data     (f_push_data)
   );

   // Absorb output stalls so the front end keeps taking requests.
   mpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (f_push_ready),
      .push_data  (f_push_data),
      .pop_valid  (b_pop_valid),
      .pop_ready  (b_pop_ready),
      .pop_data   (b_pop_data)
   );

   // Count, advance the sample row and drain results.
   mpc_back #(
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .row_count (row_count_ff),
      .pop_valid (b_pop_valid),
      .pop_ready (b_pop_ready),
      .pop_data  (b_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/mpc_queue.sv =====
// Short register FIFO that decouples the front end from the counting back end.
// Depends on mpc_pkg.
`default_nettype none

module mpc_queue
   import mpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   output      logic        push_ready,
   input  wire q_entry_type push_data,
   output      logic        pop_valid,
   input  wire logic        pop_ready,
   output      q_entry_type pop_data
);

   q_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mpc_front.sv =====
// Front end: accepts requests, writes reference words, reads the reference
// banks for sample words, flags row ends and masks. Depends on mpc_pkg.
`default_nettype none

module mpc_front
   import mpc_pkg::*;
#(
   parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [WPR_W-1:0]  words_per_row,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req_data,
   output      logic              push_valid,
   input  wire logic              push_ready,
   output      q_entry_type       push_data
);

   localparam int unsigned ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [WIDX_EXT_W-1:0] widx_ext;
   logic [ADDR_W-1:0]     addr;
   logic                  in_range;
   logic                  row_end;
   logic                  accept, wr_en, rd_en;
   logic                  s1_free;

   logic                  s1_valid_ff, s1_valid_in;
   logic [WORD_W-1:0]     s1_data_ff;
   logic                  s1_row_end_ff;
   logic                  s1_inrange_ff;
   logic [WORD_W-1:0]     masked [NUM_REF];

   assign widx_ext = WIDX_EXT_W'(req_data.word_index);
   assign addr     = widx_ext[ADDR_W-1:0];
   assign in_range = widx_ext < WIDX_EXT_W'(MAX_WORDS);
   // Out-of-range row lengths give an end index no 10-bit index can match.
   assign row_end  = ({1'b0, req_data.word_index} == (words_per_row - 1'b1));

   assign s1_free   = !s1_valid_ff || push_ready;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_data.mode == MODE_LOAD) && in_range;
   assign rd_en     = accept && (req_data.mode == MODE_SAMPLE);

   always_comb begin
      if (s1_free) begin
         s1_valid_in = rd_en;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_data_ff    <= req_data.data_word;
         s1_row_end_ff <= row_end;
         s1_inrange_ff <= in_range;
      end
   end

   for (genvar g = 0; g < NUM_REF; g++) begin : g_bank
      logic [WORD_W-1:0] mem_ff [MAX_WORDS];
      logic [WORD_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (req_data.ref_row == REF_ROW_W'(g))) begin
            mem_ff[addr] <= req_data.data_word;
         end
         if (rd_en) begin
            rd_ff <= mem_ff[addr];
         end
      end

      assign masked[g] = s1_inrange_ff ? (s1_data_ff & rd_ff) : '0;
   end

   always_comb begin
      push_valid        = s1_valid_ff;
      push_data.row_end = s1_row_end_ff;
      for (int j = 0; j < NUM_REF; j++) begin
         push_data.word[j] = masked[j];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mpc_back.sv =====
// Back end: popcounts masked words, keeps the three saturating counters and
// the sample row, and drains three results per finished row. Depends on mpc_pkg.
`default_nettype none

module mpc_back
   import mpc_pkg::*;
#(
   parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ROWCNT_W-1:0]  row_count,
   input  wire logic                 pop_valid,
   output      logic                 pop_ready,
   input  wire q_entry_type          pop_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data
);

   // popcount input stage
   logic                 pa_valid_ff, pa_valid_in;
   q_entry_type          pa_entry_ff;
   // accumulate stage
   logic                 pb_valid_ff, pb_valid_in;
   logic                 pb_row_end_ff;
   logic [PC_W-1:0]      pb_pc_ff [NUM_REF];
   // running counters and row
   logic [COUNT_W-1:0]   cnt_ff [NUM_REF];
   logic [COUNT_W-1:0]   cnt_in [NUM_REF];
   logic [COUNT_W-1:0]   sat [NUM_REF];
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROWCNT_W-1:0]  row_next;
   // result buffer
   logic                 emit_valid_ff, emit_valid_in;
   logic [SEL_W-1:0]     emit_sel_ff, emit_sel_in;
   logic [ENTRY_W-1:0]   emit_base_ff, emit_base_in;
   logic [COUNT_W-1:0]   emit_cnt_ff [NUM_REF];

   logic                 emit_free, pb_adv, pb_load_ok, pa_load_ok, do_pop, rsp_fire;

   assign rsp_fire   = emit_valid_ff && rsp_ready;
   assign emit_free  = !emit_valid_ff || (rsp_fire && (emit_sel_ff == LAST_SEL));
   assign pb_adv     = pb_valid_ff && (!pb_row_end_ff || emit_free);
   assign pb_load_ok = !pb_valid_ff || pb_adv;
   assign pa_load_ok = !pa_valid_ff || pb_load_ok;
   assign pop_ready  = pa_load_ok;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      pa_valid_in = pa_load_ok ? pop_valid : pa_valid_ff;
      pb_valid_in = pb_load_ok ? pa_valid_ff : pb_valid_ff;
   end

   always_comb begin
      for (int j = 0; j < NUM_REF; j++) begin
         logic [COUNT_W:0] sum;
         sum    = {1'b0, cnt_ff[j]} + (COUNT_W + 1)'(pb_pc_ff[j]);
         sat[j] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      end
   end

   assign row_next = ROWCNT_W'(row_ff) + 1'b1;

   always_comb begin
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      emit_valid_in = emit_valid_ff;
      emit_sel_in   = emit_sel_ff;
      emit_base_in  = emit_base_ff;
      if (rsp_fire) begin
         if (emit_sel_ff == LAST_SEL) begin
            emit_valid_in = 1'b0;
         end else begin
            emit_sel_in = emit_sel_ff + 1'b1;
         end
      end
      if (pb_adv) begin
         if (pb_row_end_ff) begin
            for (int j = 0; j < NUM_REF; j++) begin
               cnt_in[j] = '0;
            end
            emit_valid_in = 1'b1;
            emit_sel_in   = '0;
            emit_base_in  = ENTRY_W'({row_ff, 1'b0}) + ENTRY_W'(row_ff);
            if ((row_next >= row_count) || (32'(row_next) >= 32'(MAX_ROWS))) begin
               row_in = '0;
            end else begin
               row_in = row_next[ROW_W-1:0];
            end
         end else begin
            cnt_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff   <= 1'b0;
         pb_valid_ff   <= 1'b0;
         emit_valid_ff <= 1'b0;
         emit_sel_ff   <= '0;
         row_ff        <= '0;
         for (int j = 0; j < NUM_REF; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         pa_valid_ff   <= pa_valid_in;
         pb_valid_ff   <= pb_valid_in;
         emit_valid_ff <= emit_valid_in;
         emit_sel_ff   <= emit_sel_in;
         row_ff        <= row_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         pa_entry_ff <= pop_data;
      end
      if (pb_load_ok && pa_valid_ff) begin
         pb_row_end_ff <= pa_entry_ff.row_end;
         for (int j = 0; j < NUM_REF; j++) begin
            pb_pc_ff[j] <= popcount64(pa_entry_ff.word[j]);
         end
      end
      emit_base_ff <= emit_base_in;
      if (pb_adv && pb_row_end_ff) begin
         emit_cnt_ff <= sat;
      end
   end

   always_comb begin
      rsp_valid            = emit_valid_ff;
      rsp_data.entry_index = emit_base_ff + ENTRY_W'(emit_sel_ff);
      rsp_data.count       = emit_cnt_ff[emit_sel_ff];
      rsp_data.last        = (emit_sel_ff == LAST_SEL);
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_masked_popcount_contingency.sv =====
// Self-checking testbench for masked_popcount_contingency: loads reference words,
// streams sample rows, predicts the three masked popcounts of every row and checks
// each response in order. Depends on mpc_pkg and the RTL top level.
module tb_masked_popcount_contingency;
   timeunit 1ns;
   timeprecision 1ps;

   import mpc_pkg::*;

   localparam int unsigned MAX_WORDS     = DEF_MAX_WORDS;
   localparam int unsigned MAX_ROWS      = DEF_MAX_ROWS;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam logic [WORD_W-1:0] ALT_BITS = {32{2'b01}};
   localparam logic [REF_ROW_W-1:0] UNUSED_ROW = REF_ROW_W'(NUM_REF);

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports. Drive every input to a known value from time 0.
   // ---------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_WORDS_PER_ROW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   masked_popcount_contingency u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Stimulus side: requests waiting for the driver, and what the generator knows
   // about the reference store so that no sample ever reads an unloaded word.
   // ---------------------------------------------------------------------------
   req_type     request_backlog[$];
   bit          gen_loaded [NUM_REF][MAX_WORDS];
   int unsigned gen_wpr            = 1;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   logic        hold_request       = 1'b0;
   int unsigned hold_left          = 0;

   // ---------------------------------------------------------------------------
   // Predictor state: its own copy of the reference rows, the three running
   // tallies, the sample row number and both registers, at their reset values.
   // ---------------------------------------------------------------------------
   logic [WORD_W-1:0]   ref_words [NUM_REF][MAX_WORDS];
   logic [COUNT_W-1:0]  tallies [NUM_REF] = '{default: '0};
   logic [ROW_W-1:0]    row_num  = '0;
   logic [WPR_W-1:0]    cfg_wpr  = WPR_W'(1);
   logic [ROWCNT_W-1:0] cfg_rows = ROWCNT_W'(1);
   rsp_type             expected_counts[$];
   int unsigned         mismatch_count = 0;

   // Apply one accepted request to the predictor; queue three counts on a row end.
   function automatic void tally_request(input req_type r);
      int unsigned sum;
      int unsigned next_row;
      rsp_type     res;
      if (r.mode == MODE_LOAD) begin
         // Row three has no storage: drop the write.
         if (r.ref_row < NUM_REF) ref_words[r.ref_row][r.word_index] = r.data_word;
         return;
      end
      for (int j = 0; j < NUM_REF; j++) begin
         sum = tallies[j] + $countones(r.data_word & ref_words[j][r.word_index]);
         tallies[j] = (sum > COUNT_MAX) ? COUNT_MAX : COUNT_W'(sum);
      end
      // A row length of zero or beyond the store never matches any index.
      if (cfg_wpr == 0 || cfg_wpr > MAX_WORDS || r.word_index != cfg_wpr - 1) return;
      for (int j = 0; j < NUM_REF; j++) begin
         res.entry_index = ENTRY_W'(row_num * NUM_REF + j);
         res.count       = tallies[j];
         res.last        = (j == NUM_REF - 1);
         expected_counts.push_back(res);
         tallies[j] = '0;
      end
      // Wrap at row_count or at the table size, whichever comes first.
      next_row = row_num + 1;
      if (next_row >= cfg_rows || next_row >= MAX_ROWS) next_row = 0;
      row_num = ROW_W'(next_row);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, msg);
   endfunction

   // ---------------------------------------------------------------------------
   // Request generation. None of these advance time.
   // ---------------------------------------------------------------------------
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return '1;
         1:       return '0;
         2:       return ALT_BITS;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void push_load(input logic [REF_ROW_W-1:0] row, input int unsigned idx,
                                     input logic [WORD_W-1:0] data);
      req_type item;
      item.mode       = MODE_LOAD;
      item.ref_row    = row;
      item.word_index = WIDX_W'(idx);
      item.data_word  = data;
      request_backlog.push_back(item);
      if (row < NUM_REF) gen_loaded[row][idx] = 1'b1;
   endfunction

   // Load any reference word at this index that was never written, then send the sample.
   function automatic void push_sample(input int unsigned idx, input logic [WORD_W-1:0] data);
      req_type item;
      for (int j = 0; j < NUM_REF; j++) begin
         if (!gen_loaded[j][idx]) push_load(REF_ROW_W'(j), idx, pick_word());
      end
      item.mode       = MODE_SAMPLE;
      item.ref_row    = REF_ROW_W'($urandom_range(NUM_REF));   // ignored on samples
      item.word_index = WIDX_W'(idx);
      item.data_word  = data;
      request_backlog.push_back(item);
   endfunction

   // Pick a word index that does not close the current row; favor a small hot set.
   function automatic int unsigned pick_filler_index();
      int unsigned idx;
      do begin
         case ($urandom_range(19)) inside
            [0:2]:   idx = MAX_WORDS - 1;
            [3:5]:   idx = $urandom_range(MAX_WORDS - 1);
            default: idx = $urandom_range(7);
         endcase
      end while (idx + 1 == gen_wpr);
      return idx;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: predict on acceptance, then offer the next request unless idling.
   // Hold valid and payload steady while the block stalls.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) tally_request(req_data);
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare each accepted response with the oldest expected count.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               note_mismatch($sformatf("unexpected response entry %0d count %0d last %0b",
                                       rsp_data.entry_index, rsp_data.count, rsp_data.last));
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.entry_index !== want.entry_index)
                  note_mismatch($sformatf("entry_index expected %0d got %0d",
                                          want.entry_index, rsp_data.entry_index));
               if (rsp_data.count !== want.count)
                  note_mismatch($sformatf("count of entry %0d expected %0d got %0d",
                                          want.entry_index, want.count, rsp_data.count));
               if (rsp_data.last !== want.last)
                  note_mismatch($sformatf("last of entry %0d expected %0b got %0b",
                                          want.entry_index, want.last, rsp_data.last));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencing helpers, run from the main initial block.
   // ---------------------------------------------------------------------------
   // Return on a falling edge once every request is in and every count is out,
   // then let the pipeline settle so rows that emit nothing are finished too.
   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register while the block is idle and mirror it in the predictor.
   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_WORDS_PER_ROW) begin
         cfg_wpr = WPR_W'(value);
         gen_wpr = cfg_wpr;
      end else begin
         cfg_rows = ROWCNT_W'(value);
      end
      @(negedge clock);
   endtask

   // Mostly well-formed rows with random content, plus reference rewrites,
   // loads to the missing fourth row and stray words that spill into the next row.
   task automatic random_phase(input int unsigned sender_pct, input int unsigned stall_pct,
                               input int unsigned quota);
      int unsigned issued;
      int unsigned prior;
      bit          ignored;
      wait_drained();
      case ($urandom_range(5))
         0:       write_csr(CSR_WORDS_PER_ROW, 1);
         1:       write_csr(CSR_WORDS_PER_ROW, 2);
         2:       write_csr(CSR_WORDS_PER_ROW, $urandom_range(3, 16));
         3:       write_csr(CSR_WORDS_PER_ROW, MAX_WORDS);
         default: write_csr(CSR_WORDS_PER_ROW, $urandom_range(1, MAX_WORDS));
      endcase
      case ($urandom_range(5))
         0:       write_csr(CSR_ROW_COUNT, 0);
         1:       write_csr(CSR_ROW_COUNT, 1);
         2:       write_csr(CSR_ROW_COUNT, $urandom_range(2, 7));
         3:       write_csr(CSR_ROW_COUNT, (1 << ROWCNT_W) - 1);
         default: write_csr(CSR_ROW_COUNT, $urandom_range((1 << ROWCNT_W) - 1));
      endcase
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = stall_pct;
      issued = 0;
      while (issued < quota) begin
         prior   = request_backlog.size();
         ignored = 1'b0;
         case ($urandom_range(19)) inside
            [0:1]: push_load(REF_ROW_W'($urandom_range(NUM_REF - 1)), pick_filler_index(),
                             pick_word());
            2: begin
               push_load(UNUSED_ROW, $urandom_range(MAX_WORDS - 1), pick_word());
               ignored = 1'b1;
            end
            3: push_sample(pick_filler_index(), pick_word());
            default: begin
               repeat ($urandom_range(3)) push_sample(pick_filler_index(), pick_word());
               push_sample(gen_wpr - 1, pick_word());
            end
         endcase
         if (!ignored) issued += request_backlog.size() - prior;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset configuration, one-word rows, one row per table.
      push_load(REF_ROW_W'(0), 0, '1);
      push_load(REF_ROW_W'(1), 0, ALT_BITS);
      push_load(REF_ROW_W'(2), 0, {$urandom, $urandom});
      push_load(UNUSED_ROW, 0, '0);        // the missing fourth row must not touch the store
      push_sample(0, '1);
      push_sample(0, '0);
      push_sample(0, {$urandom, $urandom});

      // Longest legal row, closed by the top word index; row count zero acts like one.
      wait_drained();
      write_csr(CSR_WORDS_PER_ROW, MAX_WORDS);
      write_csr(CSR_ROW_COUNT, 0);
      push_sample(0, pick_word());
      push_sample(MAX_WORDS - 1, '1);

      // Two-word rows, two rows per table.
      wait_drained();
      write_csr(CSR_WORDS_PER_ROW, 2);
      write_csr(CSR_ROW_COUNT, 2);
      repeat (2) begin
         push_sample(0, pick_word());
         push_sample(1, pick_word());
      end

      // Row length zero: rows never close, so the tallies keep growing.
      wait_drained();
      write_csr(CSR_WORDS_PER_ROW, 0);
      for (int j = 0; j < NUM_REF; j++) push_load(REF_ROW_W'(j), 0, '1);
      repeat (8) push_sample(0, '1);

      // Row length beyond the store: still nothing closes.
      wait_drained();
      write_csr(CSR_WORDS_PER_ROW, (1 << WPR_W) - 1);
      repeat (3) push_sample(0, pick_word());

      // Close the long row.
      wait_drained();
      write_csr(CSR_WORDS_PER_ROW, 1);
      write_csr(CSR_ROW_COUNT, 3);
      push_sample(0, '1);

      // Largest row count: rows advance without wrapping.
      wait_drained();
      write_csr(CSR_ROW_COUNT, (1 << ROWCNT_W) - 1);
      for (int j = 0; j < NUM_REF; j++) push_load(REF_ROW_W'(j), 0, {$urandom, $urandom});
      repeat (4) push_sample(0, pick_word());

      // Back-pressure: hold the receiver off while one-word rows keep arriving,
      // so the queue fills and the block drops req_ready.
      wait_drained();
      write_csr(CSR_ROW_COUNT, 5);
      @(posedge clock);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      @(negedge clock);
      repeat (20) push_sample(0, pick_word());

      // Random part, one pacing mode per phase.
      random_phase(0, 0, 15);
      random_phase(73, 0, 15);
      random_phase(0, 73, 15);
      random_phase(6, 6, 15);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Give up well past the slowest correct run.
   initial begin
      #1ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
